### design/assert_macros.svh
// Assertion macros used by the checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form of the above
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### design/ddm_pkg.sv
// Package for the differential drive mixer: widths, codes and beat types.
// No dependencies.
`timescale 1ns / 1ps
package ddm_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int SW          = SPEED_WIDTH;
    localparam int FRAC        = SW - 2;
    localparam int QW          = SW - 1;      // quotient width, quotients never exceed 1.0
    localparam int DW          = 18;          // divisor width
    localparam int NW          = SW + 19;     // dividend width
    localparam int MW          = SW + 18;     // arc product width
    localparam int PW          = SW + 32;     // curvature product width
    localparam int CW          = SW + 34;     // curvature numerator width
    localparam int CURV_SHIFT  = 21;
    localparam int DDM_LATENCY = QW + 5;
    localparam logic [15:0] BASE_RESET = 16'd256;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC;

    typedef enum logic [2:0] {
        CMD_TANK      = 3'd0,
        CMD_ARCADE    = 3'd1,
        CMD_CURVATURE = 3'd2,
        CMD_ROTATE    = 3'd3,
        CMD_ARC       = 3'd4
    } cmd_e;

    typedef struct packed {
        logic [2:0]             command;
        logic signed [SW-1:0]   first_speed;
        logic signed [SW-1:0]   second_speed;
        logic signed [15:0]     curvature_in;
        logic signed [15:0]     arc_radius;
        logic                   reverse_allowed;
    } drive_cmd_t;

    typedef struct packed {
        logic signed [SW-1:0]   left_target;
        logic signed [SW-1:0]   right_target;
    } wheel_targets_t;

    // Sideband that rides along the divider
    typedef struct packed {
        logic signed [SW-1:0]   direct_l;
        logic signed [SW-1:0]   direct_r;
        logic                   use_div;
        logic                   arc_sat;
        logic                   neg_l;
        logic                   neg_r;
    } ddm_side_t;

endpackage

### design/differential_drive_mixer_core.sv
// Pipeline: a start beat passes through four operand stages, one divider stage per quotient bit
// and one output stage before its result strobe.
// Throughput: one command per cycle, busy stays low; the divider pipeline sets the depth.
// Reset: asynchronous, active low; clears all valid bits and sets the wheel base to BASE_RESET.
// Top level of the differential drive mixer.
// Depends on ddm_pkg, ddm_front, ddm_divider, ddm_back.
`timescale 1ns / 1ps
module differential_drive_mixer_core
    import ddm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  drive_cmd_t      drive,
    output logic            done,
    output wheel_targets_t  targets,
    input  logic            base_we,
    input  logic [15:0]     base_wdata
);

    logic [15:0] base_reg;

    // wheel base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_RESET;
        else if (base_we)
            base_reg <= base_wdata;
    end

    assign busy = 1'b0;

    logic          fr_valid;
    ddm_side_t     fr_side;
    logic [NW-1:0] fr_num_a;
    logic [DW-1:0] fr_den_a;
    logic [NW-1:0] fr_num_b;
    logic [DW-1:0] fr_den_b;
    logic          dv_valid;
    ddm_side_t     dv_side;
    logic [QW-1:0] dv_quo_a;
    logic [QW-1:0] dv_quo_b;

    ddm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .drive      (drive),
        .base_len   (base_reg),
        .out_valid  (fr_valid),
        .side       (fr_side),
        .num_a      (fr_num_a),
        .den_a      (fr_den_a),
        .num_b      (fr_num_b),
        .den_b      (fr_den_b)
    );

    ddm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .num_a     (fr_num_a),
        .den_a     (fr_den_a),
        .num_b     (fr_num_b),
        .den_b     (fr_den_b),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo_a     (dv_quo_a),
        .quo_b     (dv_quo_b)
    );

    ddm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .side     (dv_side),
        .quo_a    (dv_quo_a),
        .quo_b    (dv_quo_b),
        .done     (done),
        .targets  (targets)
    );

endmodule

### design/ddm_front.sv
// Operand stages of the mixer: direct modes, products, curvature rounding, divider setup.
// Depends on ddm_pkg.
`timescale 1ns / 1ps
module ddm_front
    import ddm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  drive_cmd_t         drive,
    input  logic [15:0]        base_len,
    output logic               out_valid,
    output ddm_side_t          side,
    output logic [NW-1:0]      num_a,
    output logic [DW-1:0]      den_a,
    output logic [NW-1:0]      num_b,
    output logic [DW-1:0]      den_b
);

    // round to nearest (ties away from zero) by 2^CURV_SHIFT, then saturate
    function automatic logic signed [SW-1:0] round_sat(input logic signed [CW-1:0] n);
        logic [CW-1:0] m;
        logic [CW-1:0] q;
        logic signed [SW-1:0] r;
        m = (n < 0) ? CW'(-n) : CW'(n);
        q = (m + (CW'(1) << (CURV_SHIFT - 1))) >> CURV_SHIFT;
        if (n < 0)
        begin
            if (q > CW'({1'b1, {(SW-1){1'b0}}}))
                r = SMIN;
            else
                r = -SW'(q);
        end
        else
        begin
            if (q > CW'(SMAX))
                r = SMAX;
            else
                r = SW'(q);
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] neg_sat(input logic signed [SW-1:0] v);
        return (v == SMIN) ? SMAX : -v;
    endfunction

    // ---- stage 1: capture beat and wheel base
    logic        s1_valid_reg;
    drive_cmd_t  s1_cmd_reg;
    logic [15:0] s1_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= drive;
        s1_base_reg <= base_len;
    end

    // ---- stage 1 -> 2: direct results, first products, arc terms
    logic signed [SW-1:0]    a1;
    logic signed [SW:0]      sum1;
    logic signed [SW:0]      dif1;
    logic signed [SW-1:0]    dl2_next;
    logic signed [SW-1:0]    dr2_next;
    logic signed [SW+15:0]   ac2_next;
    logic [SW-1:0]           absa2_next;
    logic [15:0]             absr1;
    logic [16:0]             d2_next;
    logic signed [DW-1:0]    dm1;
    logic [DW-1:0]           dp2_next;
    logic [16:0]             absdm2_next;
    logic                    negl2_next;
    logic                    usediv2_next;
    logic                    curv2_next;
    logic                    swap2_next;

    always_comb
    begin
        a1    = s1_cmd_reg.first_speed;
        sum1  = (SW+1)'(a1) + (SW+1)'(s1_cmd_reg.second_speed);
        dif1  = (SW+1)'(a1) - (SW+1)'(s1_cmd_reg.second_speed);
        dl2_next = '0;
        dr2_next = '0;
        case (s1_cmd_reg.command)
            CMD_TANK:
            begin
                dl2_next = a1;
                dr2_next = s1_cmd_reg.second_speed;
            end
            CMD_ARCADE:
            begin
                if (sum1 > (SW+1)'(ONE))
                    dl2_next = ONE;
                else if (sum1 < -(SW+1)'(ONE))
                    dl2_next = -ONE;
                else
                    dl2_next = SW'(sum1);
                if (dif1 > (SW+1)'(ONE))
                    dr2_next = ONE;
                else if (dif1 < -(SW+1)'(ONE))
                    dr2_next = -ONE;
                else
                    dr2_next = SW'(dif1);
            end
            CMD_ROTATE, CMD_ARC:
            begin
                dl2_next = a1;
                dr2_next = neg_sat(a1);
            end
            default:
            begin
                dl2_next = '0;
                dr2_next = '0;
            end
        endcase
        ac2_next    = (SW+16)'(a1) * (SW+16)'(s1_cmd_reg.curvature_in);
        absa2_next  = (a1 < 0) ? SW'(-a1) : SW'(a1);
        absr1       = (s1_cmd_reg.arc_radius < 0) ? 16'(-s1_cmd_reg.arc_radius)
                                                  : 16'(s1_cmd_reg.arc_radius);
        d2_next     = {absr1, 1'b0};
        dm1         = $signed(DW'(d2_next)) - $signed(DW'(s1_base_reg));
        dp2_next    = DW'(d2_next) + DW'(s1_base_reg);
        absdm2_next = (dm1 < 0) ? 17'(-dm1) : 17'(dm1);
        negl2_next  = (a1 < 0) ^ (dm1 < 0) ^ (s1_cmd_reg.arc_radius < 0);
        usediv2_next = (s1_cmd_reg.command == CMD_ARC) && (s1_cmd_reg.arc_radius != 0);
        curv2_next  = (s1_cmd_reg.command == CMD_CURVATURE);
        swap2_next  = s1_cmd_reg.reverse_allowed && (a1 < 0);
    end

    logic                    s2_valid_reg;
    logic signed [SW-1:0]    s2_a_reg;
    logic [15:0]             s2_base_reg;
    logic signed [SW-1:0]    s2_dl_reg;
    logic signed [SW-1:0]    s2_dr_reg;
    logic signed [SW+15:0]   s2_ac_reg;
    logic [SW-1:0]           s2_absa_reg;
    logic [16:0]             s2_d_reg;
    logic [DW-1:0]           s2_dp_reg;
    logic [16:0]             s2_absdm_reg;
    logic                    s2_negl_reg;
    logic                    s2_usediv_reg;
    logic                    s2_curv_reg;
    logic                    s2_swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg      <= a1;
        s2_base_reg   <= s1_base_reg;
        s2_dl_reg     <= dl2_next;
        s2_dr_reg     <= dr2_next;
        s2_ac_reg     <= ac2_next;
        s2_absa_reg   <= absa2_next;
        s2_d_reg      <= d2_next;
        s2_dp_reg     <= dp2_next;
        s2_absdm_reg  <= absdm2_next;
        s2_negl_reg   <= negl2_next;
        s2_usediv_reg <= usediv2_next;
        s2_curv_reg   <= curv2_next;
        s2_swap_reg   <= swap2_next;
    end

    // ---- stage 2 -> 3: second products
    logic signed [PW-1:0] p3_next;
    logic [MW-1:0]        ml3_next;
    logic [MW-1:0]        mr3_next;

    always_comb
    begin
        p3_next  = PW'(s2_ac_reg) * PW'($signed({1'b0, s2_base_reg}));
        ml3_next = MW'(s2_absa_reg) * MW'(s2_absdm_reg);
        mr3_next = MW'(s2_absa_reg) * MW'(s2_dp_reg);
    end

    logic                    s3_valid_reg;
    logic signed [SW-1:0]    s3_a_reg;
    logic signed [SW-1:0]    s3_dl_reg;
    logic signed [SW-1:0]    s3_dr_reg;
    logic signed [PW-1:0]    s3_p_reg;
    logic [MW-1:0]           s3_ml_reg;
    logic [MW-1:0]           s3_mr_reg;
    logic [16:0]             s3_d_reg;
    logic [DW-1:0]           s3_dp_reg;
    logic [16:0]             s3_absdm_reg;
    logic                    s3_negl_reg;
    logic                    s3_usediv_reg;
    logic                    s3_curv_reg;
    logic                    s3_swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_a_reg      <= s2_a_reg;
        s3_dl_reg     <= s2_dl_reg;
        s3_dr_reg     <= s2_dr_reg;
        s3_p_reg      <= p3_next;
        s3_ml_reg     <= ml3_next;
        s3_mr_reg     <= mr3_next;
        s3_d_reg      <= s2_d_reg;
        s3_dp_reg     <= s2_dp_reg;
        s3_absdm_reg  <= s2_absdm_reg;
        s3_negl_reg   <= s2_negl_reg;
        s3_usediv_reg <= s2_usediv_reg;
        s3_curv_reg   <= s2_curv_reg;
        s3_swap_reg   <= s2_swap_reg;
    end

    // ---- stage 3 -> 4: curvature result, divider operands
    logic signed [CW-1:0] ash;
    logic signed [SW-1:0] cl;
    logic signed [SW-1:0] cr;
    logic                 arc_sat;
    ddm_side_t            side_next;
    logic [NW-1:0]        numa_next;
    logic [DW-1:0]        dena_next;
    logic [NW-1:0]        numb_next;

    always_comb
    begin
        ash = CW'(s3_a_reg) <<< CURV_SHIFT;
        cl  = round_sat(ash - CW'(s3_p_reg));
        cr  = round_sat(ash + CW'(s3_p_reg));
        side_next.direct_l = s3_dl_reg;
        side_next.direct_r = s3_dr_reg;
        if (s3_curv_reg)
        begin
            side_next.direct_l = s3_swap_reg ? cr : cl;
            side_next.direct_r = s3_swap_reg ? cl : cr;
        end
        // larger wheel over 1.0: normalize against d+b
        arc_sat = s3_mr_reg > (MW'(s3_d_reg) << FRAC);
        side_next.use_div = s3_usediv_reg;
        side_next.arc_sat = arc_sat;
        side_next.neg_l   = s3_negl_reg;
        side_next.neg_r   = (s3_a_reg < 0);
        if (arc_sat)
        begin
            numa_next = (NW'(s3_absdm_reg) << FRAC) + NW'(s3_dp_reg >> 1);
            dena_next = s3_dp_reg;
        end
        else
        begin
            numa_next = NW'(s3_ml_reg) + NW'(s3_d_reg >> 1);
            dena_next = DW'(s3_d_reg);
        end
        numb_next = NW'(s3_mr_reg) + NW'(s3_d_reg >> 1);
    end

    logic          s4_valid_reg;
    ddm_side_t     s4_side_reg;
    logic [NW-1:0] s4_numa_reg;
    logic [DW-1:0] s4_dena_reg;
    logic [NW-1:0] s4_numb_reg;
    logic [DW-1:0] s4_denb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_side_reg <= side_next;
        s4_numa_reg <= numa_next;
        s4_dena_reg <= dena_next;
        s4_numb_reg <= numb_next;
        s4_denb_reg <= DW'(s3_d_reg);
    end

    assign out_valid = s4_valid_reg;
    assign side      = s4_side_reg;
    assign num_a     = s4_numa_reg;
    assign den_a     = s4_dena_reg;
    assign num_b     = s4_numb_reg;
    assign den_b     = s4_denb_reg;

endmodule

### design/ddm_divider.sv
// Pipelined restoring divider pair, one quotient bit per stage, sideband alongside.
// Depends on ddm_pkg.
`timescale 1ns / 1ps
module ddm_divider
    import ddm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ddm_side_t      in_side,
    input  logic [NW-1:0]  num_a,
    input  logic [DW-1:0]  den_a,
    input  logic [NW-1:0]  num_b,
    input  logic [DW-1:0]  den_b,
    output logic           out_valid,
    output ddm_side_t      out_side,
    output logic [QW-1:0]  quo_a,
    output logic [QW-1:0]  quo_b
);

    logic           vld_reg  [QW];
    ddm_side_t      side_reg [QW];
    logic [NW-1:0]  ra_reg   [QW];
    logic [DW-1:0]  da_reg   [QW];
    logic [QW-1:0]  qa_reg   [QW];
    logic [NW-1:0]  rb_reg   [QW];
    logic [DW-1:0]  db_reg   [QW];
    logic [QW-1:0]  qb_reg   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic          v_in;
        ddm_side_t     s_in;
        logic [NW-1:0] ra_in;
        logic [DW-1:0] da_in;
        logic [QW-1:0] qa_in;
        logic [NW-1:0] rb_in;
        logic [DW-1:0] db_in;
        logic [QW-1:0] qb_in;
        logic [NW-1:0] sha;
        logic [NW-1:0] shb;
        logic [NW-1:0] ra_next;
        logic [QW-1:0] qa_next;
        logic [NW-1:0] rb_next;
        logic [QW-1:0] qb_next;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign s_in  = in_side;
            assign ra_in = num_a;
            assign da_in = den_a;
            assign qa_in = '0;
            assign rb_in = num_b;
            assign db_in = den_b;
            assign qb_in = '0;
        end
        else
        begin : g_next
            assign v_in  = vld_reg[k-1];
            assign s_in  = side_reg[k-1];
            assign ra_in = ra_reg[k-1];
            assign da_in = da_reg[k-1];
            assign qa_in = qa_reg[k-1];
            assign rb_in = rb_reg[k-1];
            assign db_in = db_reg[k-1];
            assign qb_in = qb_reg[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb
        begin
            sha = NW'(da_in) << BIT;
            shb = NW'(db_in) << BIT;
            ra_next = ra_in;
            qa_next = qa_in;
            rb_next = rb_in;
            qb_next = qb_in;
            if (ra_in >= sha)
            begin
                ra_next = ra_in - sha;
                qa_next = qa_in | (QW'(1) << BIT);
            end
            if (rb_in >= shb)
            begin
                rb_next = rb_in - shb;
                qb_next = qb_in | (QW'(1) << BIT);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= s_in;
            ra_reg[k]   <= ra_next;
            da_reg[k]   <= da_in;
            qa_reg[k]   <= qa_next;
            rb_reg[k]   <= rb_next;
            db_reg[k]   <= db_in;
            qb_reg[k]   <= qb_next;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign quo_a     = qa_reg[QW-1];
    assign quo_b     = qb_reg[QW-1];

endmodule

### design/ddm_back.sv
// Result stage: applies arc signs, picks the mode result, registers the result beat.
// Depends on ddm_pkg.
`timescale 1ns / 1ps
module ddm_back
    import ddm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ddm_side_t       side,
    input  logic [QW-1:0]   quo_a,
    input  logic [QW-1:0]   quo_b,
    output logic            done,
    output wheel_targets_t  targets
);

    logic signed [SW-1:0] qa;
    logic signed [SW-1:0] qb;
    wheel_targets_t       res_next;
    logic                 done_reg;
    wheel_targets_t       res_reg;

    // quotients stay within 1.0, so negation cannot overflow
    always_comb
    begin
        qa = $signed(SW'(quo_a));
        qb = $signed(SW'(quo_b));
        res_next.left_target  = side.direct_l;
        res_next.right_target = side.direct_r;
        if (side.use_div)
        begin
            res_next.left_target = side.neg_l ? -qa : qa;
            if (side.arc_sat)
                res_next.right_target = side.neg_r ? -ONE : ONE;
            else
                res_next.right_target = side.neg_r ? -qb : qb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done    = done_reg;
    assign targets = res_reg;

endmodule

### design/ddm_checker.sv
// Port-level checker for the mixer top level, attached by bind.
// Depends on ddm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddm_checker
    import ddm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  drive_cmd_t      drive,
    input  logic            done,
    input  wheel_targets_t  targets
);

    // every accepted beat gives exactly one strobe at fixed latency
    `ASSERT_IMPL(a_done_follows, start && !busy, ##DDM_LATENCY done, "missing result strobe")
    `ASSERT_IMPL(a_done_has_cause, done, $past(start && !busy, DDM_LATENCY), "spurious strobe")

    // tank passes speeds through
    `ASSERT_IMPL(a_tank_pass,
        done && $past(drive.command == CMD_TANK, DDM_LATENCY),
        targets.left_target == $past(drive.first_speed, DDM_LATENCY)
        && targets.right_target == $past(drive.second_speed, DDM_LATENCY),
        "tank result differs from input")

    // arcade results stay within +-1.0
    `ASSERT_IMPL(a_arcade_clamp,
        done && $past(drive.command == CMD_ARCADE, DDM_LATENCY),
        targets.left_target <= ONE && targets.left_target >= -ONE
        && targets.right_target <= ONE && targets.right_target >= -ONE,
        "arcade result out of range")

endmodule

bind differential_drive_mixer_core ddm_checker u_ddm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .drive   (drive),
    .done    (done),
    .targets (targets)
);
